// ===== sv/compass_heading_and_field_magnitude_core_assert.svh =====
// Assertion macros used by the compass core checker.
`ifndef COMPASS_HEADING_AND_FIELD_MAGNITUDE_CORE_ASSERT_SVH
`define COMPASS_HEADING_AND_FIELD_MAGNITUDE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CHFM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chfm check failed");

// Next-cycle implication, disabled while reset is high.
`define CHFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chfm check failed");

`endif

// ===== sv/chfm_pkg.sv =====
// Constants, widths and the arctangent table of the compass heading core.
package chfm_pkg;

   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_TABLE_LEN = 24;
   localparam int SQRT_STEPS      = 16;
   localparam int ITER_LEN        = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
   localparam int CNT_W           = $clog2(ANGLE_TABLE_LEN);

   localparam int ANGLE_FRAC_BITS = 8;
   localparam int XY_W            = 27;
   localparam int ANG_W           = 25;
   localparam int ATAN_W          = 21;
   localparam int H_W             = 18;

   localparam int FULL_TURN         = 36000;
   localparam int HALF_TURN         = 18000;
   localparam int QUARTER_TURN      = 9000;
   localparam int DECLINATION_RESET = 1171;

   localparam logic [31:0] SQRT_BIT_INIT = 32'h4000_0000;

   // atan(2^-i) in 1/256 centidegree
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      unique case (idx)
         5'd0:    v = 21'd1152000;
         5'd1:    v = 21'd680065;
         5'd2:    v = 21'd359328;
         5'd3:    v = 21'd182400;
         5'd4:    v = 21'd91554;
         5'd5:    v = 21'd45822;
         5'd6:    v = 21'd22916;
         5'd7:    v = 21'd11459;
         5'd8:    v = 21'd5730;
         5'd9:    v = 21'd2865;
         5'd10:   v = 21'd1432;
         5'd11:   v = 21'd716;
         5'd12:   v = 21'd358;
         5'd13:   v = 21'd179;
         5'd14:   v = 21'd90;
         5'd15:   v = 21'd45;
         5'd16:   v = 21'd22;
         5'd17:   v = 21'd11;
         5'd18:   v = 21'd6;
         5'd19:   v = 21'd3;
         5'd20:   v = 21'd1;
         5'd21:   v = 21'd1;
         default: v = 21'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/compass_heading_and_field_magnitude_core.sv =====
// Compass heading (vectoring CORDIC) and field magnitude (bitwise square root) core.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   status, x_raw, y_raw, z_raw
//   rsp      out        rsp_valid / rsp_ready   heading_centideg, magnitude, updated
//   csr      in         csr_valid / csr_ready   declination_centideg
//
// A request passes a setup state, a squaring state that sums x, y and z squared on the
// shared 16x16 multiplier (only when status bit 0 is set), an iteration state in which the
// CORDIC stage and the square root stage step together, and a round and a wrap state.
// req_ready is high only when idle. A waiting response stalls only the wrap state.
// Synchronous reset clears the held axes and magnitude and loads the declination
// reset value.
module compass_heading_and_field_magnitude_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_status,
   input  logic signed [15:0] req_x_raw,
   input  logic signed [15:0] req_y_raw,
   input  logic signed [15:0] req_z_raw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_heading_centideg,
   output logic [15:0]        rsp_magnitude,
   output logic               rsp_updated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [15:0] csr_declination_centideg
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_SQUARE = 3'd2;
   localparam logic [2:0] ST_ITER   = 3'd3;
   localparam logic [2:0] ST_ROUND  = 3'd4;
   localparam logic [2:0] ST_WRAP   = 3'd5;

   localparam int                        CNT_W  = chfm_pkg::CNT_W;
   localparam int                        XY_W   = chfm_pkg::XY_W;
   localparam int                        ANG_W  = chfm_pkg::ANG_W;
   localparam int                        H_W    = chfm_pkg::H_W;
   localparam int                        FRAC   = chfm_pkg::ANGLE_FRAC_BITS;
   localparam logic [CNT_W-1:0]          SQ_LAST   = CNT_W'(2);
   localparam logic [CNT_W-1:0]          ITER_LAST = CNT_W'(chfm_pkg::ITER_LEN - 1);
   localparam logic signed [ANG_W-1:0]   ANG_HALF  =
      ANG_W'(chfm_pkg::HALF_TURN * (2 ** chfm_pkg::ANGLE_FRAC_BITS));
   localparam logic signed [ANG_W-1:0]   ANG_RND   = ANG_W'(2 ** (chfm_pkg::ANGLE_FRAC_BITS - 1));
   localparam logic signed [H_W-1:0]     H_FULL    = H_W'(chfm_pkg::FULL_TURN);

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [15:0]              held_x_ff, held_x_in;
   logic [15:0]              held_y_ff, held_y_in;
   logic [15:0]              held_z_ff, held_z_in;
   logic [15:0]              held_mag_ff, held_mag_in;
   logic [15:0]              decl_ff, decl_in;
   logic                     upd_ff, upd_in;
   logic [31:0]              op_ff, op_in;
   logic [31:0]              res_ff, res_in;
   logic [31:0]              bit_ff, bit_in;
   logic signed [XY_W-1:0]   cx_ff, cx_in;
   logic signed [XY_W-1:0]   cy_ff, cy_in;
   logic signed [ANG_W-1:0]  ang_ff, ang_in;
   logic signed [H_W-1:0]    h_ff, h_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_heading_ff, rsp_heading_in;
   logic [15:0]              rsp_mag_ff, rsp_mag_in;
   logic                     rsp_upd_ff, rsp_upd_in;

   logic                     req_fire;
   logic                     out_free;
   logic signed [15:0]       sq_op;
   logic signed [31:0]       sq_prod;
   logic [31:0]              trial;
   logic signed [XY_W-1:0]   x_init, y_init, dx, dy;
   logic [chfm_pkg::ATAN_W-1:0] atan_val;
   logic signed [ANG_W-1:0]  atan_ext, ang_rnd;
   logic signed [H_W-1:0]    h_raw, h_wrap;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_heading_centideg = rsp_heading_ff;
   assign rsp_magnitude        = rsp_mag_ff;
   assign rsp_updated          = rsp_upd_ff;

   // shared datapath pieces
   always_comb begin
      case (cnt_ff)
         CNT_W'(0): sq_op = $signed(held_x_ff);
         CNT_W'(1): sq_op = $signed(held_y_ff);
         default:   sq_op = $signed(held_z_ff);
      endcase
      sq_prod  = sq_op * sq_op;
      trial    = res_ff + bit_ff;
      x_init   = $signed({{(XY_W-16-FRAC){held_x_ff[15]}}, held_x_ff, {FRAC{1'b0}}});
      y_init   = $signed({{(XY_W-16-FRAC){held_y_ff[15]}}, held_y_ff, {FRAC{1'b0}}});
      dx       = cy_ff >>> cnt_ff;
      dy       = cx_ff >>> cnt_ff;
      atan_val = chfm_pkg::atan_entry(cnt_ff);
      atan_ext = $signed({{(ANG_W-chfm_pkg::ATAN_W){1'b0}}, atan_val});
      ang_rnd  = ang_ff + ANG_RND;
      h_raw    = $signed({ang_rnd[ANG_W-1], ang_rnd[ANG_W-1:FRAC]})
               - $signed({{(H_W-16){decl_ff[15]}}, decl_ff});
      if (h_ff < 0) begin
         h_wrap = h_ff + H_FULL;
      end else if (h_ff >= H_FULL) begin
         h_wrap = h_ff - H_FULL;
      end else begin
         h_wrap = h_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      held_z_in      = held_z_ff;
      held_mag_in    = held_mag_ff;
      decl_in        = decl_ff;
      upd_in         = upd_ff;
      op_in          = op_ff;
      res_in         = res_ff;
      bit_in         = bit_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      ang_in         = ang_ff;
      h_in           = h_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_heading_in = rsp_heading_ff;
      rsp_mag_in     = rsp_mag_ff;
      rsp_upd_in     = rsp_upd_ff;

      if (csr_valid) begin
         decl_in = csr_declination_centideg;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               upd_in = req_status[0];
               if (req_status[0]) begin
                  held_x_in = req_x_raw;
                  held_y_in = req_y_raw;
                  held_z_in = req_z_raw;
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cnt_in = '0;
            op_in  = '0;
            res_in = '0;
            bit_in = chfm_pkg::SQRT_BIT_INIT;
            // turn a left-half vector by a half turn
            if (held_x_ff[15]) begin
               cx_in  = -x_init;
               cy_in  = -y_init;
               ang_in = ANG_HALF;
            end else begin
               cx_in  = x_init;
               cy_in  = y_init;
               ang_in = '0;
            end
            state_in = upd_ff ? ST_SQUARE : ST_ITER;
         end
         ST_SQUARE: begin
            op_in = op_ff + $unsigned(sq_prod);
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = ST_ITER;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_ITER: begin
            if (cnt_ff < CNT_W'(chfm_pkg::SQRT_STEPS)) begin
               if (op_ff >= trial) begin
                  op_in  = op_ff - trial;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
            if (cnt_ff < CNT_W'(chfm_pkg::CORDIC_STEPS)) begin
               if (!cy_ff[XY_W-1]) begin
                  cx_in  = cx_ff + dx;
                  cy_in  = cy_ff - dy;
                  ang_in = ang_ff + atan_ext;
               end else begin
                  cx_in  = cx_ff - dx;
                  cy_in  = cy_ff + dy;
                  ang_in = ang_ff - atan_ext;
               end
            end
            if (cnt_ff == ITER_LAST) begin
               state_in = ST_ROUND;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_ROUND: begin
            if (upd_ff) begin
               held_mag_in = res_ff[15:0] + {15'd0, (op_ff > res_ff)};
            end
            h_in     = h_raw[H_W-1] ? h_raw + H_FULL : h_raw;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mag_in   = held_mag_ff;
               rsp_upd_in   = upd_ff;
               if (held_x_ff == 16'd0) begin
                  rsp_heading_in = held_y_ff[15] ? 16'(chfm_pkg::QUARTER_TURN) : 16'd0;
               end else begin
                  rsp_heading_in = h_wrap[15:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         held_z_ff    <= '0;
         held_mag_ff  <= '0;
         decl_ff      <= 16'(chfm_pkg::DECLINATION_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         held_z_ff    <= held_z_in;
         held_mag_ff  <= held_mag_in;
         decl_ff      <= decl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      upd_ff         <= upd_in;
      op_ff          <= op_in;
      res_ff         <= res_in;
      bit_ff         <= bit_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      ang_ff         <= ang_in;
      h_ff           <= h_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_mag_ff     <= rsp_mag_in;
      rsp_upd_ff     <= rsp_upd_in;
   end

endmodule

// ===== sv/chfm_checker.sv =====
// Port-level checker for the compass core and its bind statement.
`include "compass_heading_and_field_magnitude_core_assert.svh"

module chfm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_status,
   input logic signed [15:0] req_x_raw,
   input logic signed [15:0] req_y_raw,
   input logic signed [15:0] req_z_raw,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [15:0]        rsp_heading_centideg,
   input logic [15:0]        rsp_magnitude,
   input logic               rsp_updated,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic signed [15:0] csr_declination_centideg
);

   logic [32:0] rsp_payload;

   assign rsp_payload = {rsp_heading_centideg, rsp_magnitude, rsp_updated};

   // the core is busy in the cycle after it accepts a request
   `CHFM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `CHFM_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid))
   `CHFM_ASSERT_NOW(a_heading_range, clock, reset, rsp_valid, rsp_heading_centideg < 16'd36000)
   `CHFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind compass_heading_and_field_magnitude_core chfm_checker u_chfm_checker (.*);

// ===== bench/tb.sv =====
// Self-checking testbench for the compass heading and field magnitude core.
module tb;

   localparam int DATA_READY_BIT = 0;
   localparam int STALL_LIMIT    = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [15:0] heading;
      logic [15:0] magnitude;
      logic        updated;
   } compass_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_status = '0;
   logic signed [15:0] req_x_raw = '0;
   logic signed [15:0] req_y_raw = '0;
   logic signed [15:0] req_z_raw = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_heading_centideg;
   logic [15:0]        rsp_magnitude;
   logic               rsp_updated;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic signed [15:0] csr_declination = '0;

   // predictor state
   logic signed [15:0] held_x = '0;
   logic signed [15:0] held_y = '0;
   logic [15:0]        held_mag = '0;
   logic signed [15:0] decl_setting = 16'(chfm_pkg::DECLINATION_RESET);

   // atan(2^-i) in 1/256 centidegree
   int arctan_lut [24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                           5730, 2865, 1432, 716, 358, 179, 90, 45,
                           22, 11, 6, 3, 1, 1, 0, 0};

   compass_result_type due_readings [$];
   int  failures = 0;
   int  quiet_cycles = 0;
   int  rsp_hold_request = 0;
   int  rsp_hold_left = 0;
   bit  calm = 1'b0;

   compass_heading_and_field_magnitude_core i_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_status               (req_status),
      .req_x_raw                (req_x_raw),
      .req_y_raw                (req_y_raw),
      .req_z_raw                (req_z_raw),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_heading_centideg     (rsp_heading_centideg),
      .rsp_magnitude            (rsp_magnitude),
      .rsp_updated              (rsp_updated),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_declination_centideg (csr_declination)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] rounded_root(input longint unsigned s);
      longint unsigned rem, root, b;
      rem  = s;
      root = 0;
      b    = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem  -= root + b;
            root  = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      if (rem > root) root++;
      return root[15:0];
   endfunction

   function automatic logic [15:0] heading_from(input logic signed [15:0] x,
                                                input logic signed [15:0] y,
                                                input logic signed [15:0] decl);
      int cx, cy, ang, h, dx, dy, i;
      if (x == 0) return (y < 0) ? 16'(chfm_pkg::QUARTER_TURN) : 16'd0;
      cx  = int'(x) * 256;
      cy  = int'(y) * 256;
      ang = 0;
      // turn the left half plane over to the right
      if (cx < 0) begin
         cx  = -cx;
         cy  = -cy;
         ang = chfm_pkg::HALF_TURN * 256;
      end
      for (i = 0; i < chfm_pkg::CORDIC_STEPS && i < chfm_pkg::ANGLE_TABLE_LEN; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy >= 0) begin
            cx  += dx;
            cy  -= dy;
            ang += arctan_lut[i];
         end else begin
            cx  -= dx;
            cy  += dy;
            ang -= arctan_lut[i];
         end
      end
      h = ((ang + 128) >>> chfm_pkg::ANGLE_FRAC_BITS) - int'(decl);
      h = h % chfm_pkg::FULL_TURN;
      if (h < 0) h += chfm_pkg::FULL_TURN;
      return h[15:0];
   endfunction

   function automatic compass_result_type compass_reading(input logic [7:0] status,
                                                          input logic signed [15:0] x,
                                                          input logic signed [15:0] y,
                                                          input logic signed [15:0] z);
      compass_result_type r;
      longint unsigned sumsq;
      if (status[DATA_READY_BIT]) begin
         held_x   = x;
         held_y   = y;
         sumsq    = longint'(x) * longint'(x) + longint'(y) * longint'(y)
                  + longint'(z) * longint'(z);
         held_mag = rounded_root(sumsq);
      end
      r.heading   = heading_from(held_x, held_y, decl_setting);
      r.magnitude = held_mag;
      r.updated   = status[DATA_READY_BIT];
      return r;
   endfunction

   function automatic logic signed [15:0] pick_axis();
      case ($urandom_range(9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         3, 4:    return 16'($signed($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_poll(input logic [7:0] status, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 24) gap = $urandom_range(25, 1);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_status <= status;
      req_x_raw  <= x;
      req_y_raw  <= y;
      req_z_raw  <= z;
      do @(posedge clock); while (!req_ready);
      due_readings.push_back(compass_reading(status, x, y, z));
   endtask

   task automatic send_random_poll();
      logic [7:0] status;
      status = 8'($urandom);
      status[DATA_READY_BIT] = ($urandom_range(99) < 75);
      send_poll(status, pick_axis(), pick_axis(), pick_axis());
   endtask

   // drop valid and wait for every outstanding request to come back
   task automatic drain_readings();
      req_valid <= 1'b0;
      while (due_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_declination(input logic signed [15:0] value);
      @(posedge clock);
      csr_valid       <= 1'b1;
      csr_declination <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      decl_setting  = value;
   endtask

   task automatic test_reset_state();
      send_poll(8'h00, 16'sd1234, -16'sd77, 16'sd5);
      send_poll(8'hFE, -16'sd4000, 16'sd9000, 16'sd1);
   endtask

   task automatic test_directed_extremes();
      send_poll(8'h01, 16'sh7FFF, 16'sd0, 16'sd0);
      send_poll(8'hFF, 16'sh8000, 16'sh8000, 16'sh8000);
      send_poll(8'h01, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_poll(8'h01, 16'sd0, -16'sd1, 16'sd0);
      send_poll(8'h03, 16'sd0, 16'sd1, 16'sd0);
      send_poll(8'h01, 16'sd0, 16'sd0, 16'sh8000);
      send_poll(8'h01, -16'sd1, 16'sd0, 16'sd0);
      send_poll(8'h01, -16'sd100, -16'sd1, 16'sd3);
      send_poll(8'h01, -16'sd100, 16'sd1, -16'sd3);
      send_poll(8'h80, 16'sd11, 16'sd22, 16'sd33);
      send_poll(8'h01, 16'sd1, 16'sh8000, 16'sd0);
      send_poll(8'h01, 16'sh8000, 16'sh7FFF, 16'sd0);
      send_poll(8'h01, 16'sd300, 16'sd300, -16'sd300);
      send_poll(8'h01, -16'sd300, 16'sd300, 16'sd0);
      send_poll(8'h01, 16'sh8000, 16'sd0, 16'sd0);
      send_poll(8'h55, 16'sd1, 16'sd1, 16'sd1);
      send_poll(8'hAA, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
   endtask

   task automatic test_declination_sweep();
      logic signed [15:0] settings [6];
      int k, n;
      settings[0] = -16'sd18000;
      settings[1] = 16'sd18000;
      settings[2] = 16'sd0;
      settings[3] = 16'sh8000;
      settings[4] = 16'sh7FFF;
      settings[5] = 16'($signed($urandom_range(36000)) - 18000);
      for (k = 0; k < 6; k++) begin
         drain_readings();
         write_declination(settings[k]);
         for (n = 0; n < 150; n++) send_random_poll();
      end
   endtask

   task automatic test_backpressure();
      int n;
      rsp_hold_request = HOLD_CYCLES;
      for (n = 0; n < 40; n++) send_random_poll();
      // pause until everything has come back
      drain_readings();
   endtask

   task automatic test_steady_stream();
      int n;
      calm = 1'b1;
      for (n = 0; n < 300; n++) send_random_poll();
      calm = 1'b0;
   endtask

   task automatic test_random_mix();
      int k, n;
      for (k = 0; k < 4; k++) begin
         drain_readings();
         write_declination(16'($signed($urandom_range(36000)) - 18000));
         for (n = 0; n < 150; n++) send_random_poll();
      end
   endtask

   // receiver: random stalls, calm stretches and one long hold-off
   always @(posedge clock) begin
      if (rsp_hold_request != 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 24);
      end
   end

   always @(posedge clock) begin : rsp_check
      compass_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_readings.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected response: heading %0d magnitude %0d updated %0d",
                        rsp_heading_centideg, rsp_magnitude, rsp_updated);
         end else begin
            want = due_readings.pop_front();
            if (rsp_heading_centideg !== want.heading || rsp_magnitude !== want.magnitude ||
                rsp_updated !== want.updated) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("mismatch: heading %0d/%0d magnitude %0d/%0d updated %0d/%0d",
                           want.heading, rsp_heading_centideg, want.magnitude,
                           rsp_magnitude, want.updated, rsp_updated);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_extremes();
      test_declination_sweep();
      test_backpressure();
      test_steady_stream();
      test_random_mix();
      drain_readings();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_readings.size() != 0) begin
         failures += due_readings.size();
         $display("%0d responses never arrived", due_readings.size());
      end
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/chfm_pkg.sv
sv/compass_heading_and_field_magnitude_core.sv
sv/chfm_checker.sv
bench/tb.sv
